// ===== hw/rtl/pixel_replicate_zoom_unit_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef PIXEL_REPLICATE_ZOOM_UNIT_DEFINES_SVH
`define PIXEL_REPLICATE_ZOOM_UNIT_DEFINES_SVH

// Checked on every edge out of reset.
`define PRZ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PRZ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/prz_pkg.sv =====
package prz_pkg;

	localparam int PIXEL_BITS  = 32;
	localparam int LINE_MAX    = 4096;
	localparam int XFAC_MAX    = 64;
	localparam int YFAC_MAX    = 256;
	localparam int COL_BITS    = $clog2(LINE_MAX);
	localparam int LW_BITS     = COL_BITS + 1;
	localparam int XF_BITS     = $clog2(XFAC_MAX) + 1;
	localparam int RR_BITS     = $clog2(YFAC_MAX);
	localparam int YF_BITS     = RR_BITS + 1;
	localparam int CFG_BITS    = 13;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int LEVEL_BITS  = QPTR_BITS + 1;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [COL_BITS-1:0]   col_t;
	typedef logic [LW_BITS-1:0]    lw_t;
	typedef logic [XF_BITS-1:0]    xf_t;
	typedef logic [YF_BITS-1:0]    yf_t;
	typedef logic [RR_BITS-1:0]    rr_t;
	typedef logic [CFG_BITS-1:0]   cfg_data_t;
	typedef logic [QPTR_BITS-1:0]  qptr_t;
	typedef logic [LEVEL_BITS-1:0] level_t;

	typedef enum logic [1:0] {
		REG_X_FACTOR   = 2'd0,
		REG_Y_FACTOR   = 2'd1,
		REG_LINE_WIDTH = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_index_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	// One queued job: emit pixel count times, flags on the last copy.
	typedef struct packed {
		pixel_t pixel;
		xf_t    count;
		logic   eol;
		logic   eog;
		logic   drop;
	} entry_t;

	function automatic xf_t clamp_xf(xf_t v);
		xf_t r;
		r = v;
		if (v == xf_t'(0))
			r = xf_t'(1);
		else if (v > xf_t'(XFAC_MAX))
			r = xf_t'(XFAC_MAX);
		return r;
	endfunction

	function automatic yf_t clamp_yf(yf_t v);
		yf_t r;
		r = v;
		if (v == yf_t'(0))
			r = yf_t'(1);
		else if (v > yf_t'(YFAC_MAX))
			r = yf_t'(YFAC_MAX);
		return r;
	endfunction

	function automatic lw_t clamp_lw(lw_t v);
		lw_t r;
		r = v;
		if (v == lw_t'(0))
			r = lw_t'(1);
		else if (v > lw_t'(LINE_MAX))
			r = lw_t'(LINE_MAX);
		return r;
	endfunction

endpackage

// ===== hw/rtl/prz_front.sv =====
module prz_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  prz_pkg::pixel_t        s_axis_tdata,
	input  logic [0:0]             s_axis_tuser,
	input  logic                   cfg_valid,
	input  prz_pkg::reg_index_t    cfg_index,
	input  prz_pkg::cfg_data_t     cfg_data,
	input  prz_pkg::level_t        level,
	output logic                   push,
	output prz_pkg::entry_t        push_entry
);

	prz_pkg::xf_t    x_factor_q;
	prz_pkg::yf_t    y_factor_q;
	prz_pkg::lw_t    line_width_q;
	prz_pkg::col_t   column_q;
	prz_pkg::rr_t    repeat_row_q;
	prz_pkg::pixel_t line_store_q [prz_pkg::LINE_MAX];
	prz_pkg::pixel_t rdata_q;

	logic            valid_s1;
	logic            use_mem_s1;
	prz_pkg::entry_t entry_s1;

	prz_pkg::xf_t    xf_c;
	prz_pkg::yf_t    yf_c;
	prz_pkg::lw_t    lw_c;
	logic            accept;
	logic            is_tick;
	logic            capture;
	logic            eol;
	logic            eog;
	logic            wr_en;
	logic            rd_en;
	logic            emit;
	prz_pkg::entry_t entry_c;

	assign xf_c = prz_pkg::clamp_xf(x_factor_q);
	assign yf_c = prz_pkg::clamp_yf(y_factor_q);
	assign lw_c = prz_pkg::clamp_lw(line_width_q);

	// room for the word in s1 plus the new one
	assign s_axis_tready = (level + prz_pkg::level_t'(valid_s1)) <
		prz_pkg::level_t'(prz_pkg::QUEUE_DEPTH);
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign is_tick = (prz_pkg::cmd_t'(s_axis_tuser[0]) == prz_pkg::CMD_TICK);
	assign capture = (repeat_row_q == prz_pkg::rr_t'(0));
	assign eol     = (prz_pkg::lw_t'(column_q) + prz_pkg::lw_t'(1)) >= lw_c;

	always_comb begin
		eog = 1'b0;
		if (capture)
			eog = eol && (yf_c == prz_pkg::yf_t'(1));
		else
			eog = eol && ((prz_pkg::yf_t'(repeat_row_q) + prz_pkg::yf_t'(1)) >= yf_c);
	end

	assign wr_en = accept && capture && !is_tick;
	assign rd_en = accept && !capture && is_tick;
	assign emit  = accept && !(capture && is_tick);

	always_comb begin
		entry_c.pixel = s_axis_tdata;
		entry_c.count = xf_c;
		entry_c.eol   = eol;
		entry_c.eog   = eog;
		entry_c.drop  = 1'b0;
		if (!capture && !is_tick) begin
			entry_c.pixel = '0;
			entry_c.count = prz_pkg::xf_t'(1);
			entry_c.eol   = 1'b0;
			entry_c.eog   = 1'b0;
			entry_c.drop  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_factor_q   <= prz_pkg::xf_t'(1);
			y_factor_q   <= prz_pkg::yf_t'(1);
			line_width_q <= prz_pkg::lw_t'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				prz_pkg::REG_X_FACTOR:   x_factor_q   <= cfg_data[prz_pkg::XF_BITS-1:0];
				prz_pkg::REG_Y_FACTOR:   y_factor_q   <= cfg_data[prz_pkg::YF_BITS-1:0];
				prz_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data[prz_pkg::LW_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			repeat_row_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= emit;
			if (wr_en || rd_en) begin
				if (eol) begin
					column_q <= '0;
					if (capture)
						repeat_row_q <= (yf_c > prz_pkg::yf_t'(1)) ? prz_pkg::rr_t'(1) : '0;
					else
						repeat_row_q <= eog ? '0 : repeat_row_q + prz_pkg::rr_t'(1);
				end else begin
					column_q <= column_q + prz_pkg::col_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			entry_s1   <= entry_c;
			use_mem_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			line_store_q[column_q] <= s_axis_tdata;
		if (rd_en)
			rdata_q <= line_store_q[column_q];
	end

	assign push = valid_s1;

	always_comb begin
		push_entry = entry_s1;
		if (use_mem_s1)
			push_entry.pixel = rdata_q;
	end

endmodule

// ===== hw/rtl/prz_queue.sv =====
module prz_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  prz_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            head_valid,
	output prz_pkg::entry_t head_entry,
	output prz_pkg::level_t level
);

	prz_pkg::entry_t slot_q [prz_pkg::QUEUE_DEPTH];
	prz_pkg::qptr_t  wr_ptr_q;
	prz_pkg::qptr_t  rd_ptr_q;
	prz_pkg::level_t level_q;

	logic do_pop;

	assign head_valid = (level_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign level      = level_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + prz_pkg::qptr_t'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + prz_pkg::qptr_t'(1);
			if (push && !do_pop)
				level_q <= level_q + prz_pkg::level_t'(1);
			else if (!push && do_pop)
				level_q <= level_q - prz_pkg::level_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ===== hw/rtl/prz_back.sv =====
module prz_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  prz_pkg::entry_t head_entry,
	output logic            pop,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output prz_pkg::pixel_t m_axis_tdata,   // pixel_out
	output logic            m_axis_tlast,   // end_of_line
	output logic [2:0]      m_axis_tuser    // last_copy, end_of_group, dropped
);

	logic            out_valid_q;
	prz_pkg::xf_t    rem_q;
	prz_pkg::pixel_t tdata_q;
	logic            tlast_q;
	logic [2:0]      tuser_q;
	logic            eol_q;
	logic            eog_q;
	logic            drop_q;

	logic advance;
	logic more;
	logic last_rep;
	logic last_new;

	assign advance  = !out_valid_q || m_axis_tready;
	assign more     = (rem_q != '0);
	assign pop      = advance && !more && head_valid;
	assign last_rep = (rem_q == prz_pkg::xf_t'(1));
	assign last_new = (head_entry.count == prz_pkg::xf_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (advance) begin
			if (more) begin
				out_valid_q <= 1'b1;
				rem_q       <= rem_q - prz_pkg::xf_t'(1);
			end else if (head_valid) begin
				out_valid_q <= 1'b1;
				rem_q       <= head_entry.count - prz_pkg::xf_t'(1);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// tdata already holds the pixel while copies repeat
	// a dropped word carries only the drop flag
	always_ff @(posedge clk) begin
		if (advance) begin
			if (more) begin
				tlast_q <= eol_q && last_rep;
				tuser_q <= {drop_q && last_rep, eog_q && last_rep, last_rep};
			end else if (head_valid) begin
				tdata_q <= head_entry.pixel;
				eol_q   <= head_entry.eol;
				eog_q   <= head_entry.eog;
				drop_q  <= head_entry.drop;
				tlast_q <= head_entry.eol && last_new;
				tuser_q <= {head_entry.drop && last_new, head_entry.eog && last_new,
					last_new && !head_entry.drop};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;
	assign m_axis_tuser  = tuser_q;

endmodule

// ===== hw/rtl/pixel_replicate_zoom_unit.sv =====
// Integer pixel-replication zoom on a raster stream.
// Input words: tuser[0] = 0 carries a source pixel in tdata, 1 is a replay tick.
// Output words: tdata = pixel, tlast = end of output line, tuser = {dropped,
// end of group, last copy}. Config: cfg_index 0 x_factor, 1 y_factor,
// 2 line_width; always ready, write only while the block is idle.
// In capture each pixel is stored in the line store and sent x_factor times;
// after a full line each tick replays one stored pixel x_factor times, for
// y_factor-1 more lines. A pixel seen during replay yields one dropped word.
// An item's first word leaves after the s1 register, job queue and output
// register. Throughput: one input word per cycle and, while the receiver is
// ready, one output word per cycle; an item holds the replicator for all
// its copies, and input runs ahead until the four-entry job queue fills.
// When the receiver stalls, the output word holds, the queue fills and
// s_axis_tready drops. Reset empties queue and output, returns to capture at
// column 0 and sets all factors to 1; the line store is not cleared.
module pixel_replicate_zoom_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  prz_pkg::pixel_t     s_axis_tdata,   // pixel_in
	input  logic [0:0]          s_axis_tuser,   // cmd
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output prz_pkg::pixel_t     m_axis_tdata,   // pixel_out
	output logic                m_axis_tlast,   // end_of_line
	output logic [2:0]          m_axis_tuser,   // last_copy, end_of_group, dropped
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  prz_pkg::reg_index_t cfg_index,
	input  prz_pkg::cfg_data_t  cfg_data
);

	logic            push;
	prz_pkg::entry_t push_entry;
	logic            pop;
	logic            head_valid;
	prz_pkg::entry_t head_entry;
	prz_pkg::level_t level;

	assign cfg_ready = 1'b1;

	prz_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.level         (level),
		.push          (push),
		.push_entry    (push_entry)
	);

	prz_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.level      (level)
	);

	prz_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_entry    (head_entry),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== hw/rtl/prz_checker.sv =====
`include "pixel_replicate_zoom_unit_defines.svh"

module prz_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            m_axis_tvalid,
	input logic            m_axis_tready,
	input prz_pkg::pixel_t m_axis_tdata,
	input logic            m_axis_tlast,
	input logic [2:0]      m_axis_tuser
);

	// once reset is seen, nothing is offered on the next edge
	`PRZ_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |=> !m_axis_tvalid, "output word during reset")

	`PRZ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output word changed")

	// a dropped word is a lone zero word with no other flags
	`PRZ_ASSERT(a_drop_shape, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == '0 && !m_axis_tuser[0] && !m_axis_tlast && !m_axis_tuser[1], "bad dropped word")

	// line and group ends only on the last copy; group end implies line end
	`PRZ_ASSERT(a_flags_on_last, m_axis_tvalid && (m_axis_tlast || m_axis_tuser[1]) |-> m_axis_tuser[0] && (m_axis_tlast || !m_axis_tuser[1]), "end flag off last copy")

endmodule

bind pixel_replicate_zoom_unit prz_checker u_prz_checker (.*);

// ===== sim/zoom_stream_checker.sv =====
// Watches both streams and the config channel, keeps its own copy of the zoom
// state, and compares every output word with the oldest predicted word.
module zoom_stream_checker
	import prz_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  pixel_t     s_axis_tdata,   // pixel_in
	input  logic [0:0] s_axis_tuser,   // cmd
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  pixel_t     m_axis_tdata,   // pixel_out
	input  logic       m_axis_tlast,   // end_of_line
	input  logic [2:0] m_axis_tuser,   // last_copy, end_of_group, dropped
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  reg_index_t cfg_index,
	input  cfg_data_t  cfg_data,
	output int         words_pending,
	output int         mismatches
);

	typedef struct packed {
		pixel_t pixel;
		logic   last_copy;
		logic   eol;
		logic   eog;
		logic   dropped;
	} zoom_word_t;

	zoom_word_t  words_due[$];
	zoom_word_t  head_word;
	pixel_t      line_copy [LINE_MAX];
	logic [6:0]  x_setting;
	logic [8:0]  y_setting;
	logic [12:0] width_setting;
	col_t        column;
	rr_t         replay_row;

	task automatic report_mismatch(input string what);
		if (mismatches < 40)
			$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Expected words for one accepted input word.
	task automatic zoom_item(input cmd_t cmd, input pixel_t pix);
		int unsigned xf, yf, lw, k;
		logic eol, eog;
		pixel_t value;
		xf = (x_setting == 0) ? 1 : (x_setting > XFAC_MAX) ? XFAC_MAX : x_setting;
		yf = (y_setting == 0) ? 1 : (y_setting > YFAC_MAX) ? YFAC_MAX : y_setting;
		lw = (width_setting == 0) ? 1 : (width_setting > LINE_MAX) ? LINE_MAX : width_setting;
		eol = (int'(column) + 1 >= lw);
		if (replay_row == 0) begin
			if (cmd == CMD_TICK)
				return;
			value = pix;
			line_copy[column] = pix;
			eog = eol && (yf == 1);
			if (eol) begin
				column = '0;
				replay_row = (yf > 1) ? rr_t'(1) : rr_t'(0);
			end else begin
				column++;
			end
		end else if (cmd == CMD_PIXEL) begin
			// pixel during replay: one flagged word, state untouched
			words_due.push_back('{'0, 1'b0, 1'b0, 1'b0, 1'b1});
			return;
		end else begin
			value = line_copy[column];
			eog = eol && (int'(replay_row) + 1 >= yf);
			if (eol) begin
				column = '0;
				replay_row = eog ? rr_t'(0) : replay_row + 1'b1;
			end else begin
				column++;
			end
		end
		for (k = 1; k <= xf; k++)
			words_due.push_back('{value, (k == xf), eol && (k == xf), eog && (k == xf), 1'b0});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_due.delete();
			x_setting = 7'd1;
			y_setting = 9'd1;
			width_setting = 13'd1;
			column = '0;
			replay_row = '0;
			mismatches = 0;
			words_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_X_FACTOR:   x_setting = cfg_data[6:0];
					REG_Y_FACTOR:   y_setting = cfg_data[8:0];
					REG_LINE_WIDTH: width_setting = cfg_data[12:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				zoom_item(cmd_t'(s_axis_tuser[0]), s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (words_due.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
				end else begin
					head_word = words_due.pop_front();
					if (m_axis_tdata !== head_word.pixel)
						report_mismatch($sformatf("pixel %h, want %h",
							m_axis_tdata, head_word.pixel));
					if (m_axis_tlast !== head_word.eol)
						report_mismatch($sformatf("end of line %b, want %b",
							m_axis_tlast, head_word.eol));
					if (m_axis_tuser[0] !== head_word.last_copy)
						report_mismatch($sformatf("last copy %b, want %b",
							m_axis_tuser[0], head_word.last_copy));
					if (m_axis_tuser[1] !== head_word.eog)
						report_mismatch($sformatf("end of group %b, want %b",
							m_axis_tuser[1], head_word.eog));
					if (m_axis_tuser[2] !== head_word.dropped)
						report_mismatch($sformatf("dropped %b, want %b",
							m_axis_tuser[2], head_word.dropped));
				end
			end
			words_pending <= words_due.size();
		end
	end

endmodule

// ===== sim/pixel_replicate_zoom_unit_test.sv =====
module pixel_replicate_zoom_unit_test;
	import prz_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	pixel_t     s_axis_tdata = '0;   // pixel_in
	logic [0:0] s_axis_tuser = '0;   // cmd
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	pixel_t     m_axis_tdata;        // pixel_out
	logic       m_axis_tlast;        // end_of_line
	logic [2:0] m_axis_tuser;        // last_copy, end_of_group, dropped
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	reg_index_t cfg_index = REG_X_FACTOR;
	cfg_data_t  cfg_data = '0;
	int         words_pending;
	int         mismatches;

	int idle_pct = 0;
	int stall_pct = 0;
	// where the block stands in its line, used to shape the stimulus
	int trk_col = 0;
	int trk_row = 0;
	int trk_yf = 1;
	int trk_lw = 1;
	int busy_items = 0;

	pixel_replicate_zoom_unit dut (.*);

	zoom_stream_checker zoom_check (.*);

	initial forever #1 clk = ~clk;

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	task automatic send_item(input cmd_t cmd, input pixel_t pix);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		if (!(trk_row == 0 && cmd == CMD_TICK))
			busy_items++;
		if (trk_row == 0 && cmd == CMD_PIXEL) begin
			if (trk_col + 1 >= trk_lw) begin
				trk_col = 0;
				trk_row = (trk_yf > 1) ? 1 : 0;
			end else begin
				trk_col++;
			end
		end else if (trk_row != 0 && cmd == CMD_TICK) begin
			if (trk_col + 1 >= trk_lw) begin
				trk_col = 0;
				trk_row = (trk_row + 1 >= trk_yf) ? 0 : trk_row + 1;
			end else begin
				trk_col++;
			end
		end
	endtask

	task automatic write_reg(input reg_index_t idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= cfg_data_t'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_Y_FACTOR) begin
			trk_yf = value % 512;
			trk_yf = (trk_yf == 0) ? 1 : (trk_yf > YFAC_MAX) ? YFAC_MAX : trk_yf;
		end else if (idx == REG_LINE_WIDTH) begin
			trk_lw = value % 8192;
			trk_lw = (trk_lw == 0) ? 1 : (trk_lw > LINE_MAX) ? LINE_MAX : trk_lw;
		end
	endtask

	// Drain: wait until all predicted words are out, then idle on for ignored ticks.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Follow the line structure; noise_pct flips a word to the other kind.
	task automatic run_stream(input int count, input int noise_pct);
		cmd_t cmd;
		pixel_t pix;
		repeat (count) begin
			cmd = (trk_row == 0) ? CMD_PIXEL : CMD_TICK;
			if ($urandom_range(99) < noise_pct)
				cmd = (cmd == CMD_PIXEL) ? CMD_TICK : CMD_PIXEL;
			case ($urandom_range(9))
				0:       pix = '0;
				1:       pix = '1;
				default: pix = $urandom;
			endcase
			send_item(cmd, pix);
		end
	endtask

	initial begin
		int phase;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset factors: tick in capture is ignored, each pixel closes its group
		send_item(CMD_TICK, '1);
		send_item(CMD_PIXEL, '0);
		send_item(CMD_PIXEL, '1);
		settle();

		// two-pixel line, one replay line, a pixel dropped in between
		write_reg(REG_X_FACTOR, 3);
		write_reg(REG_Y_FACTOR, 2);
		write_reg(REG_LINE_WIDTH, 2);
		send_item(CMD_PIXEL, 32'h1234_5678);
		send_item(CMD_PIXEL, 32'hA5A5_5A5A);
		send_item(CMD_PIXEL, 32'hDEAD_BEEF);
		send_item(CMD_TICK, '0);
		send_item(CMD_TICK, '1);
		settle();

		// zero in every register acts as one
		write_reg(REG_X_FACTOR, 0);
		write_reg(REG_Y_FACTOR, 0);
		write_reg(REG_LINE_WIDTH, 0);
		send_item(CMD_PIXEL, 32'h8000_0001);
		settle();

		// x_factor above range saturates at 64; unused index is ignored
		write_reg(REG_X_FACTOR, 127);
		write_reg(REG_Y_FACTOR, 3);
		write_reg(REG_LINE_WIDTH, 1);
		write_reg(REG_UNUSED, 13'h1FFF);
		send_item(CMD_PIXEL, 32'h0F0F_F0F0);
		send_item(CMD_TICK, '0);
		send_item(CMD_TICK, '0);
		settle();

		// width and y_factor lowered in the middle of a line and of a group
		write_reg(REG_X_FACTOR, 2);
		write_reg(REG_Y_FACTOR, 256);
		write_reg(REG_LINE_WIDTH, 3);
		send_item(CMD_PIXEL, 32'h0000_FFFF);
		send_item(CMD_PIXEL, 32'hFFFF_0000);
		settle();
		write_reg(REG_LINE_WIDTH, 2);
		send_item(CMD_PIXEL, 32'h7FFF_FFFE);
		repeat (4) send_item(CMD_TICK, '0);
		settle();
		write_reg(REG_Y_FACTOR, 2);
		send_item(CMD_TICK, '0);
		send_item(CMD_TICK, '0);
		settle();

		busy_items = 0;
		phase = 0;
		while (busy_items < 90) begin
			settle();
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct <= 0;  end
				1: begin idle_pct = 60; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 60; end
				default: begin idle_pct = 21; stall_pct <= 21; end
			endcase
			if ($urandom_range(9) < 6) begin
				case ($urandom_range(11))
					0:       write_reg(REG_X_FACTOR, 0);
					1:       write_reg(REG_X_FACTOR, 127);
					2:       write_reg(REG_X_FACTOR, XFAC_MAX);
					default: write_reg(REG_X_FACTOR, $urandom_range(1, 4));
				endcase
			end
			if ($urandom_range(9) < 6) begin
				case ($urandom_range(15))
					0:       write_reg(REG_Y_FACTOR, 0);
					1:       write_reg(REG_Y_FACTOR, 511);
					2:       write_reg(REG_Y_FACTOR, YFAC_MAX);
					default: write_reg(REG_Y_FACTOR, $urandom_range(1, 4));
				endcase
			end
			// width moves only in capture, so replay never reaches past the stored line
			if (trk_row == 0 && $urandom_range(9) < 6) begin
				case ($urandom_range(11))
					0:       write_reg(REG_LINE_WIDTH, 0);
					1:       write_reg(REG_LINE_WIDTH, 8191);
					default: write_reg(REG_LINE_WIDTH, $urandom_range(1, 6));
				endcase
			end
			run_stream($urandom_range(4, 30), 12);
			phase++;
		end
		settle();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
